>>> sv/integer_to_radix_digits_defines.svh
// assertion macros for the radix digit converter
// define ASSERT_OFF to compile them out
`ifndef INTEGER_TO_RADIX_DIGITS_DEFINES_SVH
`define INTEGER_TO_RADIX_DIGITS_DEFINES_SVH

`ifndef ASSERT_OFF
// implication or sequence property, sampled on the rising clock edge
`define R2D_ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// plain expression that must hold on every clock edge
`define R2D_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`else
`define R2D_ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define R2D_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`endif

`endif

>>> sv/r2d_pkg.sv
// ----------------------------------------------------------------------------
// r2d_pkg
// Word types, character constants and the digit to ASCII map for the
// radix digit converter.
// ----------------------------------------------------------------------------
`default_nettype none

package r2d_pkg;

    localparam int VALUE_W = 31;
    localparam int RADIX_W = 5;
    localparam int CHAR_W  = 7;
    localparam int DIGIT_W = 4;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    localparam logic [CHAR_W-1:0]  CHAR_ZERO = 7'h30;  // '0'
    localparam logic [CHAR_W-1:0]  CHAR_A    = 7'h41;  // 'A'
    localparam logic [DIGIT_W-1:0] DEC_LIMIT = 4'd10;
    localparam logic [CHAR_W-1:0]  CHAR_ERR  = 7'h00;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
    } t_in_word;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last;
        logic              bad_radix;
    } t_out_word;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_LIMIT) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = CHAR_A + CHAR_W'(d - DEC_LIMIT);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> sv/integer_to_radix_digits.sv
// ----------------------------------------------------------------------------
// integer_to_radix_digits
// Converts a non-negative integer to upper-case ASCII digits in base 2 to 16,
// most significant digit first, with the last digit flagged.
// ----------------------------------------------------------------------------
// One shared restoring divide step retires 4 quotient bits a cycle. Digits go
// into a small buffer, least significant first, and are then read back in
// reverse, each with one buffer read and then one output load, which waits
// while the output register is full. The block takes no new word until the
// final digit sits in the output register. Zero gives the single digit '0'.
// A base outside 2 to 16 gives one word with bad_radix and last set and a
// zero character. Only the low VALUE_BITS bits of value are converted.
`default_nettype none
`include "integer_to_radix_digits_defines.svh"

module integer_to_radix_digits #(
    parameter int VALUE_BITS = 31
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire r2d_pkg::t_in_word    i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output r2d_pkg::t_out_word        o_out_data
);
    import r2d_pkg::*;

    localparam int QW   = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam int STEP = 4;
    localparam int NCH  = (QW + STEP - 1) / STEP;
    localparam int DW   = NCH * STEP;
    localparam int KW   = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int CW   = $clog2(QW + 1);
    localparam int AW   = $clog2(QW);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_EMIT
    } t_state;

    t_state              r_state;
    logic [DW-1:0]       r_div;
    logic [RADIX_W-1:0]  r_radix;
    logic [DIGIT_W-1:0]  r_rem;
    logic [KW-1:0]       r_chk;
    logic [CW-1:0]       r_cnt;
    logic                r_out_valid;
    t_out_word           r_out;
    logic [DIGIT_W-1:0]  r_rd_digit;
    logic [DIGIT_W-1:0]  r_mem [QW];

    logic                slot_free;
    logic                in_acc;
    logic                bad_radix;
    logic                last_chunk;
    logic [STEP-1:0]     n_qbits;
    logic [DIGIT_W-1:0]  n_rem;
    logic [DW-1:0]       n_div;
    logic [CW-1:0]       n_cnt_up;
    logic [CW-1:0]       n_cnt_dn;
    logic                wr_en;
    logic                out_load;

    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && slot_free;
    assign in_acc     = i_in_valid && o_in_ready;
    assign bad_radix  = (i_in_data.radix < RADIX_MIN) || (i_in_data.radix > RADIX_MAX);
    assign last_chunk = (r_chk == KW'(NCH - 1));
    assign n_cnt_up   = r_cnt + 1'b1;
    assign n_cnt_dn   = r_cnt - 1'b1;
    assign wr_en      = (r_state == S_DIV) && last_chunk;
    assign out_load   = (in_acc && bad_radix) || ((r_state == S_EMIT) && slot_free);

    // shared divide step: 4 restoring steps, partial remainder stays below the base
    always_comb begin
        logic [DIGIT_W-1:0] rem;
        logic [RADIX_W-1:0] sh;
        rem     = r_rem;
        n_qbits = '0;
        for (int j = 0; j < STEP; j++) begin
            sh = {rem, r_div[DW-1-j]};
            if (sh >= r_radix) begin
                n_qbits[STEP-1-j] = 1'b1;
                rem               = DIGIT_W'(sh - r_radix);
            end else begin
                rem = sh[DIGIT_W-1:0];
            end
        end
        n_rem = rem;
        n_div = (r_div << STEP) | DW'(n_qbits);
    end

    // digit buffer
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_cnt[AW-1:0]] <= n_rem;
        end
        if (r_state == S_READ) begin
            r_rd_digit <= r_mem[n_cnt_dn[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_chk       <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (bad_radix) begin
                            r_out.digit_char <= CHAR_ERR;
                            r_out.last       <= 1'b1;
                            r_out.bad_radix  <= 1'b1;
                            r_cnt            <= '0;
                        end else begin
                            r_div   <= DW'(i_in_data.value[QW-1:0]);
                            r_radix <= i_in_data.radix;
                            r_rem   <= '0;
                            r_chk   <= '0;
                            r_cnt   <= '0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_div <= n_div;
                    if (last_chunk) begin
                        r_rem <= '0;
                        r_chk <= '0;
                        r_cnt <= n_cnt_up;
                        // zero still yields one digit since the check follows the step
                        if (n_div == '0 || n_cnt_up == CW'(QW)) begin
                            r_state <= S_READ;
                        end
                    end else begin
                        r_rem <= n_rem;
                        r_chk <= r_chk + 1'b1;
                    end
                end
                S_READ: begin
                    r_cnt   <= n_cnt_dn;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (slot_free) begin
                        r_out.digit_char <= digit_to_ascii(r_rd_digit);
                        r_out.last       <= (r_cnt == '0);
                        r_out.bad_radix  <= 1'b0;
                        if (r_cnt == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `R2D_ASSERT_PROP(a_err_word, i_clk, i_rst_n,
        (o_out_valid && o_out_data.bad_radix) |->
            (o_out_data.last && o_out_data.digit_char == CHAR_ERR),
        "error word without last or with a character")
    `R2D_ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, (r_cnt <= CW'(QW)),
        "digit count beyond buffer depth")
    `R2D_ASSERT_PROP(a_rem_bound, i_clk, i_rst_n,
        (r_state == S_DIV) |-> (RADIX_W'(r_rem) < r_radix),
        "partial remainder not below the base")
    `R2D_ASSERT_PROP(a_div_radix, i_clk, i_rst_n,
        (r_state == S_DIV) |-> (r_radix >= RADIX_MIN && r_radix <= RADIX_MAX),
        "dividing by an out-of-range base")

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the radix digit converter. Numbers go in on a
// valid/ready channel with bursty timing; every digit word that comes out is
// checked against a digit list worked out here by repeated division. The
// output side stalls on a changing pattern. Covers zero, full-width values,
// every base from 0 to 31 and powers of the base and one below them.
// ----------------------------------------------------------------------------

module tb;

    import r2d_pkg::*;

    localparam longint unsigned VALUE_MAX      = (64'd1 << VALUE_W) - 1;
    localparam int              WATCHDOG_LIMIT = 4000;
    localparam int              TAIL_CYCLES    = 350;

    typedef enum int {RX_FREE, RX_RANDOM, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_data;

    t_out_word expected_digits[$];
    int        fail_count  = 0;
    int        burst_left  = 0;
    int        idle_cycles = 0;
    t_rx_mode  rx_mode     = RX_FREE;
    int        rx_mode_left = 0;
    int        rx_phase    = 0;

    integer_to_radix_digits dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #4 i_clk = ~i_clk;

    // digits of one number, most significant first
    function automatic void queue_radix_digits(t_in_word w);
        logic [DIGIT_W-1:0] rev_digits [VALUE_W];
        longint unsigned    quot;
        int                 n;
        t_out_word          o;
        if (w.radix < RADIX_MIN || w.radix > RADIX_MAX) begin
            o.digit_char = CHAR_ERR;
            o.last       = 1'b1;
            o.bad_radix  = 1'b1;
            expected_digits = {expected_digits, o};
            return;
        end
        quot = w.value;
        n    = 0;
        if (quot == 0) begin
            rev_digits[0] = '0;
            n = 1;
        end
        while (quot != 0 && n < VALUE_W) begin
            rev_digits[n] = DIGIT_W'(quot % w.radix);
            quot = quot / w.radix;
            n++;
        end
        for (int k = n - 1; k >= 0; k--) begin
            if (rev_digits[k] < DEC_LIMIT) begin
                o.digit_char = CHAR_ZERO + CHAR_W'(rev_digits[k]);
            end else begin
                o.digit_char = CHAR_A + CHAR_W'(rev_digits[k] - DEC_LIMIT);
            end
            o.last      = (k == 0);
            o.bad_radix = 1'b0;
            expected_digits = {expected_digits, o};
        end
    endfunction

    function automatic logic [RADIX_W-1:0] pick_radix();
        int r;
        if ($urandom_range(0, 99) < 85) begin
            return RADIX_W'($urandom_range(2, 16));
        end
        r = $urandom_range(0, 16);
        return (r < 2) ? RADIX_W'(r) : RADIX_W'(r + 15);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value(logic [RADIX_W-1:0] radix);
        longint unsigned p;
        int              k;
        p = 1;
        k = $urandom_range(0, 30);
        case ($urandom_range(0, 3))
            0: begin
                return VALUE_W'($urandom);
            end
            1: begin
                return VALUE_W'($urandom >> $urandom_range(1, 31));
            end
            2: begin
                return VALUE_W'($urandom_range(0, 300));
            end
            default: begin
                // a power of the base or one below it
                for (int i = 0; i < k && p * radix <= VALUE_MAX; i++) begin
                    p = p * radix;
                end
                return VALUE_W'($urandom_range(0, 1) ? p : p - 1);
            end
        endcase
    endfunction

    task automatic send_number(logic [VALUE_W-1:0] value, logic [RADIX_W-1:0] radix);
        t_in_word w;
        int       gap;
        w.value = value;
        w.radix = radix;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 6);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        queue_radix_digits(w);
        burst_left--;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
        end
    endtask

    task automatic wait_all_digits();
        if (burst_left != 0) begin
            i_in_valid <= 1'b0;
            burst_left = 0;
        end
        while (expected_digits.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_corner_values();
        send_number(0, 10);
        send_number(0, 2);
        send_number(0, 16);
        send_number(VALUE_W'(VALUE_MAX), 2);
        send_number(VALUE_W'(VALUE_MAX), 16);
        send_number(VALUE_W'(VALUE_MAX), 10);
        send_number(VALUE_W'(VALUE_MAX), 3);
        send_number(VALUE_W'(VALUE_MAX), 9);
        send_number(31'h4000_0000, 2);
        send_number(1, 2);
        send_number(15, 16);
        send_number(16, 16);
        send_number(10, 11);
        send_number(5, 0);
        send_number(5, 1);
        send_number(VALUE_W'(VALUE_MAX), 17);
        send_number(0, 31);
        send_number(123, 20);
        wait_all_digits();
    endtask

    task automatic test_radix_sweep();
        for (int r = 0; r < 32; r++) begin
            send_number(pick_value(RADIX_W'(r)), RADIX_W'(r));
        end
    endtask

    // one number at a time with the converter fully drained between them
    task automatic test_idle_between_numbers();
        logic [RADIX_W-1:0] r;
        for (int i = 0; i < 8; i++) begin
            r = pick_radix();
            send_number(pick_value(r), r);
            wait_all_digits();
        end
    endtask

    task automatic test_random_numbers();
        logic [RADIX_W-1:0] r;
        for (int i = 0; i < 190; i++) begin
            r = pick_radix();
            send_number(pick_value(r), r);
            if ($urandom_range(0, 39) == 0) begin
                wait_all_digits();
            end
        end
        wait_all_digits();
    endtask

    // receiver stall pattern, switching style every so often
    always @(posedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = t_rx_mode'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(20, 200);
        end else begin
            rx_mode_left--;
        end
        rx_phase = (rx_phase + 1) % 5;
        case (rx_mode)
            RX_FREE:     i_out_ready <= 1'b1;
            RX_RANDOM:   i_out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE:   i_out_ready <= ($urandom_range(0, 7) == 0);
            default:     i_out_ready <= (rx_phase != 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_digits.size() == 0) begin
                $error("unexpected word: digit_char %h last %b bad_radix %b",
                       o_out_data.digit_char, o_out_data.last, o_out_data.bad_radix);
                fail_count++;
            end else begin
                want = expected_digits.pop_front();
                if (o_out_data.digit_char !== want.digit_char) begin
                    $error("digit_char: expected %h, got %h",
                           want.digit_char, o_out_data.digit_char);
                    fail_count++;
                end
                if (o_out_data.last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, o_out_data.last);
                    fail_count++;
                end
                if (o_out_data.bad_radix !== want.bad_radix) begin
                    $error("bad_radix: expected %b, got %b",
                           want.bad_radix, o_out_data.bad_radix);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_corner_values();
        test_radix_sweep();
        test_idle_between_numbers();
        test_random_numbers();
        wait_all_digits();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_digits.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
